// ===== src/canonical_kmer_quality_roller_unit_assert.svh =====
// assertion macros for the canonical k-mer roller checker
// depends on nothing; used by kcr_checker
`ifndef CANONICAL_KMER_QUALITY_ROLLER_UNIT_ASSERT_SVH
`define CANONICAL_KMER_QUALITY_ROLLER_UNIT_ASSERT_SVH

// clocked assertion with explicit clock and reset
`define KCR_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion on the block clock and reset
`define KCR_ASSERT(lbl, prop, msg) \
   `KCR_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// ===== src/kcr_pkg.sv =====
// shared constants, types and decode functions of the canonical k-mer roller
// used by kcr_cell, kcr_quality_tree and the top level
package kcr_pkg;

   localparam int MAX_K      = 32;
   localparam int K_W        = 6;     // holds 0..MAX_K
   localparam int Q_W        = 8;
   localparam int KMER_W     = 2 * MAX_K;
   localparam int G1         = MAX_K / 4;
   localparam int G2         = G1 / 4;
   localparam int S1_W       = Q_W + 2;
   localparam int S2_W       = Q_W + 4;
   localparam int SUM_W      = 13;
   localparam int RECIP_W    = 19;
   localparam int RECIP_SHIFT = 18;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam int REQ_W      = 2 * Q_W;
   localparam int REQ_USER_W = 2;
   localparam int RSP_W      = KMER_W + 2 * Q_W;
   localparam int CSR_IDX_W  = 1;

   localparam logic [K_W-1:0] KMER_LEN_RESET = 6'd21;

   localparam logic [CSR_IDX_W-1:0] CSR_KMER_LEN    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_QUAL = 1'b1;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   localparam logic [1:0] CODE_A = 2'b00;
   localparam logic [1:0] CODE_C = 2'b01;
   localparam logic [1:0] CODE_G = 2'b10;
   localparam logic [1:0] CODE_T = 2'b11;

   typedef struct packed {
      logic shift;
      logic clear;
   } kcr_cell_ctl_type;

   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
   } kcr_tree_ctl_type;

   typedef struct packed {
      logic           valid;
      logic           qvalid;
      logic [K_W-1:0] k;
   } kcr_stage_type;

   function automatic logic [1:0] base_code(input logic [7:0] c);
      logic [1:0] r;
      unique case (c)
         CHAR_A:  r = CODE_A;
         CHAR_C:  r = CODE_C;
         CHAR_G:  r = CODE_G;
         CHAR_T:  r = CODE_T;
         default: r = CODE_A;
      endcase
      return r;
   endfunction

   // non-acgt bytes code 0 on the complement strand too
   function automatic logic [1:0] comp_code(input logic [7:0] c);
      logic [1:0] r;
      unique case (c)
         CHAR_A:  r = CODE_T;
         CHAR_C:  r = CODE_G;
         CHAR_G:  r = CODE_C;
         CHAR_T:  r = CODE_A;
         default: r = CODE_A;
      endcase
      return r;
   endfunction

   // ceil(2^18 / k), exact floor division for sums below 2^13
   function automatic logic [RECIP_W-1:0] recip(input logic [K_W-1:0] k);
      logic [RECIP_W-1:0] r;
      unique case (k)
         6'd1:    r = 19'd262144;
         6'd2:    r = 19'd131072;
         6'd3:    r = 19'd87382;
         6'd4:    r = 19'd65536;
         6'd5:    r = 19'd52429;
         6'd6:    r = 19'd43691;
         6'd7:    r = 19'd37450;
         6'd8:    r = 19'd32768;
         6'd9:    r = 19'd29128;
         6'd10:   r = 19'd26215;
         6'd11:   r = 19'd23832;
         6'd12:   r = 19'd21846;
         6'd13:   r = 19'd20165;
         6'd14:   r = 19'd18725;
         6'd15:   r = 19'd17477;
         6'd16:   r = 19'd16384;
         6'd17:   r = 19'd15421;
         6'd18:   r = 19'd14564;
         6'd19:   r = 19'd13798;
         6'd20:   r = 19'd13108;
         6'd21:   r = 19'd12484;
         6'd22:   r = 19'd11916;
         6'd23:   r = 19'd11398;
         6'd24:   r = 19'd10923;
         6'd25:   r = 19'd10486;
         6'd26:   r = 19'd10083;
         6'd27:   r = 19'd9710;
         6'd28:   r = 19'd9363;
         6'd29:   r = 19'd9040;
         6'd30:   r = 19'd8739;
         6'd31:   r = 19'd8457;
         6'd32:   r = 19'd8192;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/canonical_kmer_quality_roller_unit.sv =====
// canonical k-mer roller: takes one base and quality per item; after k-1 priming bases
// each base gives min(forward, reverse complement) plus window min and mean quality.
// throughput: one item per cycle while rsp_tready stays high, set by the cell row shifting once per item.
// path: an accepted item reaches rsp_tvalid through the cell row, 3 tree stages,
// the reciprocal multiply register and the output register.
// reset: synchronous; clears all k-mer and window state, k = 21, qualities in use.
module canonical_kmer_quality_roller_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [kcr_pkg::REQ_W-1:0]     req_tdata,  // base_char, quality
   input  logic [kcr_pkg::REQ_USER_W-1:0] req_tuser, // read_start, quality_present
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [kcr_pkg::RSP_W-1:0]     rsp_tdata,  // canonical_kmer, min_quality, mean_quality
   output logic                          rsp_tuser,  // quality_valid
   input  logic                          csr_we,
   input  logic [kcr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kcr_pkg::K_W-1:0]       csr_wdata
);

   localparam int KW    = kcr_pkg::K_W;
   localparam int QW    = kcr_pkg::Q_W;
   localparam int MAXK  = kcr_pkg::MAX_K;
   localparam int KMW   = kcr_pkg::KMER_W;
   localparam int NST   = 5;

   logic [KW-1:0] kmer_len_ff, kmer_len_in;
   logic          ign_ff, ign_in;
   logic [KW-1:0] k_eff;

   logic [KW-1:0] seen_ff, seen_in, seen_base, seen_next;
   logic          accept, emit, read_start, present, qvalid_new;
   logic [1:0]    code, comp;
   logic [QW-1:0] q_new;

   logic [1:0]    fwd  [MAXK];
   logic [1:0]    rev  [MAXK];
   logic [QW-1:0] qwin [MAXK];
   logic [KMW-1:0] fwd_vec, rev_vec;

   kcr_pkg::kcr_cell_ctl_type cell_ctl;
   kcr_pkg::kcr_tree_ctl_type tree_ctl;
   kcr_pkg::kcr_stage_type    st_ff [NST];
   kcr_pkg::kcr_stage_type    st_in [NST];
   logic [NST:0]              free;

   logic [KMW-1:0]                 canon_ff [1:NST-1];
   logic [QW-1:0]                  min3, min4_ff, mean4_ff;
   logic [kcr_pkg::SUM_W-1:0]      sum3;
   logic [kcr_pkg::PROD_W-1:0]     prod;

   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [kcr_pkg::RSP_W-1:0] rsp_data_ff;
   logic                      rsp_qv_ff;

   // configuration
   always_comb begin
      kmer_len_in = kmer_len_ff;
      ign_in      = ign_ff;
      if (csr_we) begin
         unique case (csr_index)
            kcr_pkg::CSR_KMER_LEN:    kmer_len_in = csr_wdata;
            kcr_pkg::CSR_IGNORE_QUAL: ign_in      = csr_wdata[0];
         endcase
      end
   end

   always_comb begin
      if (kmer_len_ff == '0) begin
         k_eff = KW'(1);
      end else if (kmer_len_ff > KW'(MAXK)) begin
         k_eff = KW'(MAXK);
      end else begin
         k_eff = kmer_len_ff;
      end
   end

   // input decode and priming count
   assign read_start = req_tuser[0];
   assign present    = req_tuser[1];
   assign code       = kcr_pkg::base_code(req_tdata[QW-1:0]);
   assign comp       = kcr_pkg::comp_code(req_tdata[QW-1:0]);
   assign q_new      = present ? req_tdata[2*QW-1:QW] : '0;
   assign qvalid_new = present && !ign_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      seen_base = read_start ? '0 : seen_ff;
      seen_next = (seen_base == KW'(MAXK)) ? seen_base : seen_base + KW'(1);
      emit      = seen_next >= k_eff;
      seen_in   = accept ? seen_next : seen_ff;
   end

   assign cell_ctl.shift = accept;
   assign cell_ctl.clear = read_start;

   // row of cells, cell 0 holds the newest base
   for (genvar i = 0; i < MAXK; i++) begin : g_cell
      logic [1:0]    fwd_near, rev_near;
      logic [QW-1:0] q_near;
      logic          keep, insert, head;

      if (i == 0) begin : g_head
         assign fwd_near = code;
         assign q_near   = q_new;
      end else begin : g_body
         assign fwd_near = fwd[i-1];
         assign q_near   = qwin[i-1];
      end

      if (i == MAXK - 1) begin : g_tail
         assign rev_near = 2'b00;
      end else begin : g_mid
         assign rev_near = rev[i+1];
      end

      assign head   = (i == 0);
      assign keep   = KW'(i) < k_eff;
      assign insert = KW'(i) == (k_eff - KW'(1));

      kcr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .head     (head),
         .keep     (keep),
         .insert   (insert),
         .fwd_near (fwd_near),
         .rev_near (rev_near),
         .comp     (comp),
         .q_near   (q_near),
         .fwd      (fwd[i]),
         .rev      (rev[i]),
         .q        (qwin[i])
      );
   end

   always_comb begin
      for (int i = 0; i < MAXK; i++) begin
         fwd_vec[2*i +: 2] = fwd[i];
         rev_vec[2*i +: 2] = rev[i];
      end
   end

   // stage control: a stage takes new data when empty or when its successor takes it
   always_comb begin
      free[NST] = !rsp_tvalid_ff || rsp_tready;
      for (int i = NST - 1; i >= 0; i--) begin
         free[i] = !st_ff[i].valid || free[i+1];
      end
   end

   assign req_tready = free[0];

   always_comb begin
      st_in = st_ff;
      if (free[0]) begin
         // items that only prime the state leave no entry
         st_in[0].valid  = accept && emit;
         st_in[0].qvalid = qvalid_new;
         st_in[0].k      = k_eff;
      end
      for (int j = 1; j < NST; j++) begin
         if (free[j]) st_in[j] = st_ff[j-1];
      end
      rsp_tvalid_in = free[NST] ? st_ff[NST-1].valid : rsp_tvalid_ff;
   end

   assign tree_ctl.load1 = free[1];
   assign tree_ctl.load2 = free[2];
   assign tree_ctl.load3 = free[3];

   kcr_quality_tree u_tree (
      .clock (clock),
      .ctl   (tree_ctl),
      .k     (st_ff[0].k),
      .q     (qwin),
      .min_q (min3),
      .sum_q (sum3)
   );

   assign prod = kcr_pkg::PROD_W'(sum3) * kcr_pkg::PROD_W'(kcr_pkg::recip(st_ff[3].k));

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff   <= kcr_pkg::KMER_LEN_RESET;
         ign_ff        <= 1'b0;
         seen_ff       <= '0;
         st_ff         <= '{default: '0};
         rsp_tvalid_ff <= 1'b0;
      end else begin
         kmer_len_ff   <= kmer_len_in;
         ign_ff        <= ign_in;
         seen_ff       <= seen_in;
         st_ff         <= st_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free[1]) canon_ff[1] <= (fwd_vec < rev_vec) ? fwd_vec : rev_vec;
      for (int j = 2; j < NST; j++) begin
         if (free[j]) canon_ff[j] <= canon_ff[j-1];
      end
      if (free[4]) begin
         min4_ff  <= min3;
         mean4_ff <= prod[kcr_pkg::RECIP_SHIFT +: QW];
      end
      if (free[NST]) begin
         rsp_data_ff <= {st_ff[4].qvalid ? mean4_ff : '0,
                         st_ff[4].qvalid ? min4_ff : '0,
                         canon_ff[NST-1]};
         rsp_qv_ff   <= st_ff[4].qvalid;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_qv_ff;

endmodule

// ===== src/kcr_cell.sv =====
// one position of the rolling k-mer: forward digit, reverse-complement digit
// and quality entry; depends on kcr_pkg
module kcr_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  kcr_pkg::kcr_cell_ctl_type ctl,
   input  logic                    head,
   input  logic                    keep,
   input  logic                    insert,
   input  logic [1:0]              fwd_near,
   input  logic [1:0]              rev_near,
   input  logic [1:0]              comp,
   input  logic [kcr_pkg::Q_W-1:0] q_near,
   output logic [1:0]              fwd,
   output logic [1:0]              rev,
   output logic [kcr_pkg::Q_W-1:0] q
);

   logic [1:0]              fwd_ff, fwd_in;
   logic [1:0]              rev_ff, rev_in;
   logic [kcr_pkg::Q_W-1:0] q_ff, q_in;
   logic                    drop;

   always_comb begin
      // on a read start the neighbor's old value is gone, the head takes new data
      drop   = ctl.clear && !head;
      fwd_in = fwd_ff;
      rev_in = rev_ff;
      q_in   = q_ff;
      if (ctl.shift) begin
         fwd_in = (keep && !drop) ? fwd_near : 2'b00;
         rev_in = (ctl.clear ? 2'b00 : rev_near) | (insert ? comp : 2'b00);
         q_in   = drop ? '0 : q_near;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
         rev_ff <= '0;
         q_ff   <= '0;
      end else begin
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
         q_ff   <= q_in;
      end
   end

   assign fwd = fwd_ff;
   assign rev = rev_ff;
   assign q   = q_ff;

endmodule

// ===== src/kcr_quality_tree.sv =====
// three-stage registered min and sum tree over the newest k quality entries
// depends on kcr_pkg
module kcr_quality_tree (
   input  logic                      clock,
   input  kcr_pkg::kcr_tree_ctl_type ctl,
   input  logic [kcr_pkg::K_W-1:0]   k,
   input  logic [kcr_pkg::Q_W-1:0]   q [kcr_pkg::MAX_K],
   output logic [kcr_pkg::Q_W-1:0]   min_q,
   output logic [kcr_pkg::SUM_W-1:0] sum_q
);

   localparam int KW = kcr_pkg::K_W;

   logic [kcr_pkg::Q_W-1:0]   min1_in [kcr_pkg::G1];
   logic [kcr_pkg::S1_W-1:0]  sum1_in [kcr_pkg::G1];
   logic [kcr_pkg::Q_W-1:0]   min1_ff [kcr_pkg::G1];
   logic [kcr_pkg::S1_W-1:0]  sum1_ff [kcr_pkg::G1];
   logic [kcr_pkg::Q_W-1:0]   min2_in [kcr_pkg::G2];
   logic [kcr_pkg::S2_W-1:0]  sum2_in [kcr_pkg::G2];
   logic [kcr_pkg::Q_W-1:0]   min2_ff [kcr_pkg::G2];
   logic [kcr_pkg::S2_W-1:0]  sum2_ff [kcr_pkg::G2];
   logic [kcr_pkg::Q_W-1:0]   min3_in, min3_ff;
   logic [kcr_pkg::SUM_W-1:0] sum3_in, sum3_ff;

   // leaves at or above k are left out
   always_comb begin
      logic [kcr_pkg::Q_W-1:0]  mn;
      logic [kcr_pkg::S1_W-1:0] sm;
      int                       idx;
      for (int g = 0; g < kcr_pkg::G1; g++) begin
         mn = '1;
         sm = '0;
         for (int j = 0; j < 4; j++) begin
            idx = 4 * g + j;
            if (KW'(idx) < k) begin
               if (q[idx] < mn) mn = q[idx];
               sm = sm + kcr_pkg::S1_W'(q[idx]);
            end
         end
         min1_in[g] = mn;
         sum1_in[g] = sm;
      end
   end

   always_comb begin
      logic [kcr_pkg::Q_W-1:0]  mn;
      logic [kcr_pkg::S2_W-1:0] sm;
      for (int g = 0; g < kcr_pkg::G2; g++) begin
         mn = '1;
         sm = '0;
         for (int j = 0; j < 4; j++) begin
            if (min1_ff[4 * g + j] < mn) mn = min1_ff[4 * g + j];
            sm = sm + kcr_pkg::S2_W'(sum1_ff[4 * g + j]);
         end
         min2_in[g] = mn;
         sum2_in[g] = sm;
      end
   end

   always_comb begin
      min3_in = '1;
      sum3_in = '0;
      for (int g = 0; g < kcr_pkg::G2; g++) begin
         if (min2_ff[g] < min3_in) min3_in = min2_ff[g];
         sum3_in = sum3_in + kcr_pkg::SUM_W'(sum2_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         min1_ff <= min1_in;
         sum1_ff <= sum1_in;
      end
      if (ctl.load2) begin
         min2_ff <= min2_in;
         sum2_ff <= sum2_in;
      end
      if (ctl.load3) begin
         min3_ff <= min3_in;
         sum3_ff <= sum3_in;
      end
   end

   assign min_q = min3_ff;
   assign sum_q = sum3_ff;

endmodule

// ===== src/kcr_checker.sv =====
// port-level checks of the canonical k-mer roller, bound to the top level
// depends on kcr_pkg and canonical_kmer_quality_roller_unit_assert.svh
`include "canonical_kmer_quality_roller_unit_assert.svh"

module kcr_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [kcr_pkg::RSP_W-1:0] rsp_tdata,
   input logic                      rsp_tuser
);

   // stalled result holds
   `KCR_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // quality fields are zero when not computed
   `KCR_ASSERT(a_qual_zero, rsp_tvalid && !rsp_tuser |-> rsp_tdata[kcr_pkg::RSP_W-1:kcr_pkg::KMER_W] == '0, "quality fields set without quality_valid")

   // window minimum never exceeds the truncated mean
   `KCR_ASSERT(a_min_le_mean, rsp_tvalid && rsp_tuser |-> rsp_tdata[kcr_pkg::KMER_W +: kcr_pkg::Q_W] <= rsp_tdata[kcr_pkg::KMER_W + kcr_pkg::Q_W +: kcr_pkg::Q_W], "min quality above mean")

   // no result straight out of reset
   `KCR_ASSERT(a_reset_empty, $past(reset) |-> !rsp_tvalid, "result present after reset")

endmodule

bind canonical_kmer_quality_roller_unit kcr_checker u_kcr_checker (.*);

// ===== tb/sv/canonical_kmer_quality_roller_unit_tb.sv =====
// self-checking testbench for canonical_kmer_quality_roller_unit: streams reads of bases
// through the block and compares every canonical k-mer and quality window result
// with a predictor held in a scoreboard class; depends on kcr_pkg and the rtl only
module canonical_kmer_quality_roller_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 10;   // block latency plus margin
   localparam int STALL_LIMIT   = 5000; // cycles without any accepted item or taken result
   localparam int PHASE_ITEMS   = 153;
   localparam int NUM_PHASES    = 9;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [kcr_pkg::REQ_W-1:0]       req_tdata = '0;  // base_char, quality
   logic [kcr_pkg::REQ_USER_W-1:0]  req_tuser = '0;  // read_start, quality_present
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [kcr_pkg::RSP_W-1:0]       rsp_tdata;  // canonical_kmer, min_quality, mean_quality
   logic                            rsp_tuser;  // quality_valid
   logic                            csr_we = 1'b0;
   logic [kcr_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [kcr_pkg::K_W-1:0]         csr_wdata = '0;

   int gap_pct   = 0;
   int stall_pct = 0;
   int idle_count = 0;

   typedef struct packed {
      logic [kcr_pkg::KMER_W-1:0] kmer;
      logic [kcr_pkg::Q_W-1:0]    min_q;
      logic [kcr_pkg::Q_W-1:0]    mean_q;
      logic                       qvalid;
   } kmer_result_type;

   class kmer_scoreboard;
      logic [kcr_pkg::K_W-1:0]    kmer_len;
      logic                       ignore_qual;
      logic [kcr_pkg::KMER_W-1:0] fwd_code;
      logic [kcr_pkg::KMER_W-1:0] rev_code;
      int                         bases_seen;
      logic [kcr_pkg::Q_W-1:0]    qual_window[kcr_pkg::MAX_K];
      kmer_result_type            pending_kmers[$];
      int                         mismatch_count;
      int                         base_count;
      int                         kmer_count;

      function new();
         kmer_len = kcr_pkg::KMER_LEN_RESET;
         ignore_qual = 1'b0;
         fwd_code = '0;
         rev_code = '0;
         bases_seen = 0;
         foreach (qual_window[i]) qual_window[i] = '0;
         mismatch_count = 0;
         base_count = 0;
         kmer_count = 0;
      endfunction

      function void write_register(logic [kcr_pkg::CSR_IDX_W-1:0] idx,
                                   logic [kcr_pkg::K_W-1:0] value);
         if (idx == kcr_pkg::CSR_KMER_LEN) kmer_len = value;
         else if (idx == kcr_pkg::CSR_IGNORE_QUAL) ignore_qual = value[0];
      endfunction

      // 0 acts as 1, anything above the maximum acts as the maximum
      function int effective_k();
         int k;
         k = int'(kmer_len);
         if (k == 0) k = 1;
         if (k > kcr_pkg::MAX_K) k = kcr_pkg::MAX_K;
         return k;
      endfunction

      function void add_expected(kmer_result_type r);
         pending_kmers.insert(pending_kmers.size(), r);
      endfunction

      function kmer_result_type take_expected();
         kmer_result_type r;
         r = pending_kmers[0];
         pending_kmers.delete(0);
         return r;
      endfunction

      function void roll_base(logic [7:0] ch, logic [7:0] q_in, logic start,
                              logic present);
         int                         k;
         int                         sum;
         logic [7:0]                 mn;
         logic [7:0]                 q;
         logic [1:0]                 fc;
         logic [1:0]                 rc;
         logic [kcr_pkg::KMER_W-1:0] mask;
         kmer_result_type            r;
         k = effective_k();
         mask = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
         q = present ? q_in : 8'd0;
         base_count++;
         if (start) begin
            fwd_code = '0;
            rev_code = '0;
            bases_seen = 0;
            foreach (qual_window[i]) qual_window[i] = '0;
         end
         case (ch)
            kcr_pkg::CHAR_A: begin fc = kcr_pkg::CODE_A; rc = kcr_pkg::CODE_T; end
            kcr_pkg::CHAR_C: begin fc = kcr_pkg::CODE_C; rc = kcr_pkg::CODE_G; end
            kcr_pkg::CHAR_G: begin fc = kcr_pkg::CODE_G; rc = kcr_pkg::CODE_C; end
            kcr_pkg::CHAR_T: begin fc = kcr_pkg::CODE_T; rc = kcr_pkg::CODE_A; end
            default: begin fc = kcr_pkg::CODE_A; rc = kcr_pkg::CODE_A; end
         endcase
         fwd_code = ((fwd_code << 2) | kcr_pkg::KMER_W'(fc)) & mask;
         rev_code = (rev_code >> 2) | (kcr_pkg::KMER_W'(rc) << (2 * (k - 1)));
         for (int i = kcr_pkg::MAX_K - 1; i > 0; i--) qual_window[i] = qual_window[i-1];
         qual_window[0] = q;
         sum = 0;
         mn = 8'hFF;
         for (int i = 0; i < k; i++) begin
            sum += qual_window[i];
            if (qual_window[i] < mn) mn = qual_window[i];
         end
         if (bases_seen < kcr_pkg::MAX_K) bases_seen++;
         if (bases_seen < k) return;
         r.qvalid = !ignore_qual && present;
         r.kmer   = (fwd_code < rev_code) ? fwd_code : rev_code;
         r.min_q  = r.qvalid ? mn : 8'd0;
         r.mean_q = r.qvalid ? 8'(sum / k) : 8'd0;
         add_expected(r);
      endfunction

      function void check_result(logic [kcr_pkg::RSP_W-1:0] data, logic user);
         kmer_result_type exp_r;
         kmer_count++;
         if (pending_kmers.size() == 0) begin
            $error("unexpected result: canonical_kmer %h", data[kcr_pkg::KMER_W-1:0]);
            mismatch_count++;
            return;
         end
         exp_r = take_expected();
         if (data[kcr_pkg::KMER_W-1:0] !== exp_r.kmer) begin
            $error("canonical_kmer expected %h got %h", exp_r.kmer,
                   data[kcr_pkg::KMER_W-1:0]);
            mismatch_count++;
         end
         if (data[kcr_pkg::KMER_W +: kcr_pkg::Q_W] !== exp_r.min_q) begin
            $error("min_quality expected %0d got %0d", exp_r.min_q,
                   data[kcr_pkg::KMER_W +: kcr_pkg::Q_W]);
            mismatch_count++;
         end
         if (data[kcr_pkg::KMER_W+kcr_pkg::Q_W +: kcr_pkg::Q_W] !== exp_r.mean_q) begin
            $error("mean_quality expected %0d got %0d", exp_r.mean_q,
                   data[kcr_pkg::KMER_W+kcr_pkg::Q_W +: kcr_pkg::Q_W]);
            mismatch_count++;
         end
         if (user !== exp_r.qvalid) begin
            $error("quality_valid expected %0d got %0d", exp_r.qvalid, user);
            mismatch_count++;
         end
      endfunction
   endclass

   kmer_scoreboard sb;

   canonical_kmer_quality_roller_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.roll_base(req_tdata[7:0], req_tdata[15:8], req_tuser[0], req_tuser[1]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_base(logic [7:0] ch, logic [7:0] q, logic start, logic present);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {q, ch};
      req_tuser  <= {present, start};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending, let every expected k-mer come out, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_kmers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(logic [kcr_pkg::K_W-1:0] k, logic ign);
      csr_we    <= 1'b1;
      csr_index <= kcr_pkg::CSR_KMER_LEN;
      csr_wdata <= k;
      @(posedge clock);
      sb.write_register(kcr_pkg::CSR_KMER_LEN, k);
      csr_index <= kcr_pkg::CSR_IGNORE_QUAL;
      csr_wdata <= kcr_pkg::K_W'(ign);
      @(posedge clock);
      sb.write_register(kcr_pkg::CSR_IGNORE_QUAL, kcr_pkg::K_W'(ign));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // reads of random bases, mostly long enough to give k-mers; some cut short
   task automatic run_reads(int n_items);
      logic [7:0] acgt[4];
      int         sent;
      int         len;
      int         k;
      logic       present;
      logic       first;
      logic [7:0] ch;
      logic [7:0] q;
      acgt = '{kcr_pkg::CHAR_A, kcr_pkg::CHAR_C, kcr_pkg::CHAR_G, kcr_pkg::CHAR_T};
      sent = 0;
      first = 1'b1;
      while (sent < n_items) begin
         k = sb.effective_k();
         if ($urandom_range(7) == 0) len = $urandom_range(1, k);
         else len = k + $urandom_range(0, 24);
         present = ($urandom_range(3) != 0);
         for (int j = 0; j < len && sent < n_items; j++) begin
            if ($urandom_range(9) == 0) ch = 8'($urandom_range(255));
            else ch = acgt[$urandom_range(3)];
            case ($urandom_range(9))
               0: q = 8'd0;
               1: q = 8'hFF;
               default: q = 8'($urandom_range(255));
            endcase
            if ($urandom_range(39) == 0) present = !present;
            // the first read of a phase may carry on the previous one
            send_base(ch, q, (j == 0) && !(first && $urandom_range(1) == 0), present);
            sent++;
         end
         first = 1'b0;
      end
   endtask

   initial begin
      logic [7:0] dir_chars[12];
      int         k_plan[NUM_PHASES];
      logic       ign_plan[NUM_PHASES];
      logic [7:0] q;
      sb = new();
      dir_chars = '{kcr_pkg::CHAR_A, kcr_pkg::CHAR_C, kcr_pkg::CHAR_G, kcr_pkg::CHAR_T,
                    8'h00, 8'hFF, 8'h61, 8'h4E,
                    kcr_pkg::CHAR_T, kcr_pkg::CHAR_G, kcr_pkg::CHAR_C, kcr_pkg::CHAR_A};
      k_plan   = '{21, 1, 32, 0, 63, 7, 33, 16, 0};
      ign_plan = '{0, 0, 1, 0, 1, 0, 1, 1, 0};
      k_plan[NUM_PHASES-1] = $urandom_range(2, 31);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, no read_start on the first base, non-acgt bytes,
      // quality extremes and presence switching inside the read
      for (int i = 0; i < 24; i++) begin
         case (i % 3)
            0: q = 8'hFF;
            1: q = 8'h00;
            default: q = 8'(i * 10);
         endcase
         send_base(dir_chars[i % 12], q, i == 23, (i < 18) || (i == 20));
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         if (p > 0) apply_settings(kcr_pkg::K_W'(k_plan[p]), ign_plan[p]);
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 70; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 70; end
            default: begin gap_pct = 15; stall_pct = 15; end
         endcase
         run_reads(PHASE_ITEMS);
      end
      drain();

      $display("sent %0d bases and checked %0d k-mer results over %0d register settings",
               sb.base_count, sb.kmer_count, NUM_PHASES);
      $display("k covered from below range through 32 and above, qualities on and off");
      if (sb.mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
